@@ design/igc_pkg.sv @@
// Shared types, constants and helpers for the information gain calculator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package igc_pkg;

	localparam int FV_W     = 8;
	localparam int LBL_W    = 8;
	localparam int OUT_W    = 17;
	localparam int NV_W     = 5;
	localparam int NV_RESET = 2;
	localparam int FRAC_LOG = 24;
	localparam int MANT_W   = 31;
	localparam int STEP_W   = 5;
	localparam int QCNT_W   = 5;
	localparam int RND_SH   = 7;
	localparam int SCL_SH   = 8;

	localparam int DEF_MAX_VALUES = 16;
	localparam int DEF_MAX_ROWS   = 65536;
	localparam int DEF_CNT_W      = $clog2(DEF_MAX_ROWS + 1);

	localparam logic [LBL_W-1:0] LABEL_0 = LBL_W'(0);
	localparam logic [LBL_W-1:0] LABEL_1 = LBL_W'(1);

	typedef struct packed {
		logic [FV_W-1:0]  feature_value;
		logic [LBL_W-1:0] class_label;
		logic             last_row;
	} row_t;

	typedef struct packed {
		logic [OUT_W-1:0] information_gain;
		logic [OUT_W-1:0] parent_entropy;
		logic [OUT_W-1:0] rows_seen;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROW_WR, ST_PAR_LD, ST_ENT_RD, ST_ENT_LD, ST_LOG_GO, ST_LOG_WT, ST_MUL,
		ST_ACC, ST_NEXT, ST_GAIN, ST_DIVG_GO, ST_DIVG_WT, ST_DIVP_GO, ST_DIVP_WT, ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQR} log_state_t;

	typedef enum logic [1:0] {DV_IDLE, DV_CHK, DV_ITER} div_state_t;

	typedef enum logic [1:0] {OP_N, OP_C0, OP_C1} op_sel_t;

	typedef enum logic {DS_GAIN, DS_PAR} div_sel_t;

	typedef struct packed {
		logic     row_rd;
		logic     row_wr;
		logic     par_ld;
		logic     ent_rd;
		logic     ent_ld;
		logic     log_start;
		logic     sel_next;
		logic     mul;
		logic     acc;
		logic     idx_inc;
		logic     gain;
		logic     div_start;
		div_sel_t div_sel;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic last_row;
		logic grp_empty;
		logic grp_par;
		logic sel_n;
		logic sel_c1;
		logic log_done;
		logic idx_last;
		logic div_done;
	} stat_t;

	// width of a scaled entropy sum for counts of cnt_w bits
	function automatic int sum_w(input int cnt_w);
		return cnt_w + $clog2(cnt_w) + FRAC_LOG + 1;
	endfunction

endpackage

`default_nettype wire

@@ design/igc_log2.sv @@
// Iterative base-2 logarithm of a count, integer part plus 24 fraction bits.
// Normalizes one bit a cycle, then squares the mantissa once per fraction bit. Uses igc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igc_log2 #(
	parameter int CNT_W = igc_pkg::DEF_CNT_W
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     start,
	input  wire logic [CNT_W-1:0]                         x,
	output logic                                          done,
	output logic [$clog2(CNT_W)+igc_pkg::FRAC_LOG-1:0]    res
);
	import igc_pkg::*;

	localparam int KI_W = $clog2(CNT_W);

	log_state_t             st_q, st_d;
	logic [MANT_W-1:0]      m_q;
	logic [KI_W-1:0]        k_q;
	logic [FRAC_LOG-1:0]    frac_q;
	logic [STEP_W-1:0]      step_q;
	logic                   done_q;
	logic [2*MANT_W-1:0]    sq;
	logic [MANT_W:0]        t;

	assign sq   = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
	assign t    = sq[2*MANT_W-1:MANT_W-1];
	assign res  = {k_q, frac_q};
	assign done = done_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			LG_IDLE: begin
				if (start && x != '0) st_d = LG_NORM;
			end
			LG_NORM: begin
				if (m_q[MANT_W-1]) st_d = LG_SQR;
			end
			LG_SQR: begin
				if (step_q == '0) st_d = LG_IDLE;
			end
			default: st_d = LG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= LG_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == LG_IDLE && start && x == '0) ||
			          (st_q == LG_SQR && step_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			LG_IDLE: begin
				if (start) begin
					m_q    <= MANT_W'(x) << (MANT_W - CNT_W);
					k_q    <= (x == '0) ? '0 : KI_W'(CNT_W - 1);
					frac_q <= '0;
					step_q <= STEP_W'(FRAC_LOG - 1);
				end
			end
			LG_NORM: begin
				// shift up until the leading one sits at the top
				if (!m_q[MANT_W-1]) begin
					m_q <= m_q << 1;
					k_q <= k_q - 1'b1;
				end
			end
			LG_SQR: begin
				frac_q <= {frac_q[FRAC_LOG-2:0], t[MANT_W]};
				m_q    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
				step_q <= step_q - 1'b1;
			end
			default: begin
				m_q <= m_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/igc_div.sv @@
// Restoring divider: round(num / (256 * den)), halves up, saturated to 17 bits.
// A saturation check comes first, then one quotient bit a cycle. Uses igc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igc_div #(
	parameter int CNT_W = igc_pkg::DEF_CNT_W
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [igc_pkg::sum_w(CNT_W)-1:0]     num,
	input  wire logic [CNT_W-1:0]                     den,
	output logic                                      done,
	output logic [igc_pkg::OUT_W-1:0]                 q
);
	import igc_pkg::*;

	localparam int W_D = sum_w(CNT_W) + 1;

	div_state_t        st_q, st_d;
	logic [W_D-1:0]    rem_q, dsh_q;
	logic [OUT_W-1:0]  q_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              done_q;
	logic              ge;

	assign ge   = rem_q >= dsh_q;
	assign q    = q_q;
	assign done = done_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			DV_IDLE: begin
				if (start) st_d = DV_CHK;
			end
			DV_CHK: begin
				st_d = ge ? DV_IDLE : DV_ITER;
			end
			DV_ITER: begin
				if (cnt_q == '0) st_d = DV_IDLE;
			end
			default: st_d = DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == DV_CHK && ge) || (st_q == DV_ITER && cnt_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			DV_IDLE: begin
				if (start) begin
					rem_q <= W_D'(num) + (W_D'(den) << RND_SH);
					dsh_q <= W_D'(den) << (SCL_SH + OUT_W);
					q_q   <= '0;
					cnt_q <= QCNT_W'(OUT_W - 1);
				end
			end
			DV_CHK: begin
				// quotient would not fit: saturate
				if (ge) q_q <= '1;
				else dsh_q <= dsh_q >> 1;
			end
			DV_ITER: begin
				if (ge) rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[OUT_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
				q_q <= q_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/igc_dp.sv @@
// Datapath: row counters, per-value count memories, entropy accumulation, result register.
// Driven by igc_ctrl through cmd_t/stat_t; uses igc_log2, igc_div and igc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igc_dp #(
	parameter int MAX_VALUES = igc_pkg::DEF_MAX_VALUES,
	parameter int MAX_ROWS   = igc_pkg::DEF_MAX_ROWS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire igc_pkg::cmd_t             cmd,
	output igc_pkg::stat_t                 stat,
	input  wire igc_pkg::row_t             row,
	input  wire logic                      cfg_we,
	input  wire logic [igc_pkg::NV_W-1:0]  cfg_wdata,
	output logic                           done,
	output igc_pkg::res_t                  result
);
	import igc_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ROWS + 1);
	localparam int VI_W   = $clog2(MAX_VALUES);
	localparam int KI_W   = $clog2(CNT_W);
	localparam int LOG_W  = KI_W + FRAC_LOG;
	localparam int PROD_W = CNT_W + LOG_W;
	localparam int S_W    = sum_w(CNT_W);
	localparam int EXT_W  = (CNT_W > OUT_W) ? CNT_W : OUT_W;

	logic [NV_W-1:0]       nv_q;
	logic [CNT_W-1:0]      tot_l0_q, tot_l1_q, tot_n_q;
	logic [CNT_W-1:0]      mem_l0 [MAX_VALUES];
	logic [CNT_W-1:0]      mem_l1 [MAX_VALUES];
	logic [CNT_W-1:0]      mem_n  [MAX_VALUES];
	logic [CNT_W-1:0]      rd_l0_q, rd_l1_q, rd_n_q;
	logic [MAX_VALUES-1:0] vld_q;

	logic [VI_W-1:0]       fv_s1;
	logic                  hit_s1, l0_s1, l1_s1, last_s1;

	logic [VI_W-1:0]       idx_q;
	logic [CNT_W-1:0]      grp_n_q, grp_c0_q, grp_c1_q;
	logic                  par_q;
	op_sel_t               sel_q;
	logic [LOG_W-1:0]      ln_q, diff_q;
	logic [PROD_W-1:0]     prod_q;
	logic [S_W-1:0]        sp_q, sub_q, gdiff_q;
	div_sel_t              dsel_q;
	logic [OUT_W-1:0]      gain_q, pent_q;
	res_t                  result_q;
	logic                  done_q;

	logic                  row_ok, in_rng, is0, is1, ent_vld;
	logic [VI_W-1:0]       fv_idx;
	logic [CNT_W-1:0]      op_x, base_n, base_l0, base_l1;
	logic                  log_done, div_done;
	logic [LOG_W-1:0]      log_res;
	logic [S_W-1:0]        div_num;
	logic [OUT_W-1:0]      div_q;
	logic [EXT_W-1:0]      n_ext;

	assign row_ok  = tot_n_q < CNT_W'(MAX_ROWS);
	assign in_rng  = ({1'b0, row.feature_value} < (FV_W+1)'(nv_q)) &&
	                 ({1'b0, row.feature_value} < (FV_W+1)'(MAX_VALUES));
	assign is0     = row.class_label == LABEL_0;
	assign is1     = row.class_label == LABEL_1;
	assign fv_idx  = row.feature_value[VI_W-1:0];
	assign ent_vld = vld_q[idx_q];
	assign base_n  = vld_q[fv_s1] ? rd_n_q  : '0;
	assign base_l0 = vld_q[fv_s1] ? rd_l0_q : '0;
	assign base_l1 = vld_q[fv_s1] ? rd_l1_q : '0;
	assign n_ext   = EXT_W'(tot_n_q);
	assign div_num = (cmd.div_sel == DS_GAIN) ? gdiff_q : sp_q;

	always_comb begin
		unique case (sel_q)
			OP_N:    op_x = grp_n_q;
			OP_C0:   op_x = grp_c0_q;
			OP_C1:   op_x = grp_c1_q;
			default: op_x = grp_n_q;
		endcase
	end

	igc_log2 #(.CNT_W(CNT_W)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.log_start),
		.x      (op_x),
		.done   (log_done),
		.res    (log_res)
	);

	igc_div #(.CNT_W(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (tot_n_q),
		.done   (div_done),
		.q      (div_q)
	);

	// control state and counters that reset clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q     <= NV_W'(NV_RESET);
			tot_l0_q <= '0;
			tot_l1_q <= '0;
			tot_n_q  <= '0;
			vld_q    <= '0;
			idx_q    <= '0;
			par_q    <= 1'b0;
			sel_q    <= OP_N;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) nv_q <= cfg_wdata;
			done_q <= cmd.emit;
			if (cmd.emit) begin
				tot_l0_q <= '0;
				tot_l1_q <= '0;
				tot_n_q  <= '0;
				vld_q    <= '0;
			end else if (cmd.row_rd && row_ok) begin
				tot_n_q  <= tot_n_q + 1'b1;
				tot_l0_q <= tot_l0_q + CNT_W'(is0);
				tot_l1_q <= tot_l1_q + CNT_W'(is1);
			end
			if (cmd.row_wr && hit_s1) vld_q[fv_s1] <= 1'b1;
			if (cmd.par_ld) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.par_ld) par_q <= 1'b1;
			else if (cmd.ent_ld) par_q <= 1'b0;
			if (cmd.par_ld || cmd.ent_ld) begin
				sel_q <= OP_N;
			end else if (cmd.sel_next) begin
				unique case (sel_q)
					OP_N:    sel_q <= OP_C0;
					OP_C0:   sel_q <= OP_C1;
					default: sel_q <= OP_N;
				endcase
			end
		end
	end

	// per-value count memories, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.row_wr && hit_s1) begin
			mem_n[fv_s1]  <= base_n + 1'b1;
			mem_l0[fv_s1] <= base_l0 + CNT_W'(l0_s1);
			mem_l1[fv_s1] <= base_l1 + CNT_W'(l1_s1);
		end
		if (cmd.row_rd) begin
			rd_n_q  <= mem_n[fv_idx];
			rd_l0_q <= mem_l0[fv_idx];
			rd_l1_q <= mem_l1[fv_idx];
		end else if (cmd.ent_rd) begin
			rd_n_q  <= mem_n[idx_q];
			rd_l0_q <= mem_l0[idx_q];
			rd_l1_q <= mem_l1[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_rd) begin
			fv_s1   <= fv_idx;
			hit_s1  <= row_ok && in_rng;
			l0_s1   <= is0;
			l1_s1   <= is1;
			last_s1 <= row.last_row;
		end
		if (cmd.par_ld) begin
			grp_n_q  <= tot_n_q;
			grp_c0_q <= tot_l0_q;
			grp_c1_q <= tot_l1_q;
			sp_q     <= '0;
			sub_q    <= '0;
		end else if (cmd.ent_ld) begin
			grp_n_q  <= ent_vld ? rd_n_q  : '0;
			grp_c0_q <= ent_vld ? rd_l0_q : '0;
			grp_c1_q <= ent_vld ? rd_l1_q : '0;
		end else if (cmd.acc) begin
			if (par_q) sp_q <= sp_q + S_W'(prod_q);
			else sub_q <= sub_q + S_W'(prod_q);
		end
		if (log_done) begin
			if (sel_q == OP_N) ln_q <= log_res;
			else diff_q <= ln_q - log_res;
		end
		// a zero class count gives a zero product, which drops the term
		if (cmd.mul) prod_q <= PROD_W'(op_x) * PROD_W'(diff_q);
		if (cmd.gain) gdiff_q <= (sp_q > sub_q) ? (sp_q - sub_q) : '0;
		if (cmd.div_start) dsel_q <= cmd.div_sel;
		if (div_done) begin
			if (dsel_q == DS_GAIN) gain_q <= div_q;
			else pent_q <= div_q;
		end
		if (cmd.emit) begin
			result_q.information_gain <= gain_q;
			result_q.parent_entropy   <= pent_q;
			result_q.rows_seen        <= n_ext[OUT_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		stat.last_row  = last_s1;
		stat.grp_empty = grp_n_q == '0;
		stat.grp_par   = par_q;
		stat.sel_n     = sel_q == OP_N;
		stat.sel_c1    = sel_q == OP_C1;
		stat.log_done  = log_done;
		stat.idx_last  = idx_q == VI_W'(MAX_VALUES - 1);
		stat.div_done  = div_done;
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held two cycles");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (tot_n_q == '0 && vld_q == '0))
		else $error("counters not cleared after result");

	a_row_limit: assert property (@(posedge clk) disable iff (!arst_n)
		tot_n_q <= CNT_W'(MAX_ROWS)) else $error("row total beyond limit");

endmodule

`default_nettype wire

@@ design/igc_ctrl.sv @@
// Controller state machine: row accept and write-back, entropy pass over groups, divisions.
// Talks to igc_dp through cmd_t/stat_t from igc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire igc_pkg::stat_t  stat,
	output igc_pkg::cmd_t        cmd
);
	import igc_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DS_GAIN;
		busy        = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.row_rd = 1'b1;
					state_d    = ST_ROW_WR;
				end
			end
			ST_ROW_WR: begin
				cmd.row_wr = 1'b1;
				state_d    = stat.last_row ? ST_PAR_LD : ST_IDLE;
			end
			ST_PAR_LD: begin
				cmd.par_ld = 1'b1;
				state_d    = ST_LOG_GO;
			end
			ST_ENT_RD: begin
				cmd.ent_rd = 1'b1;
				state_d    = ST_ENT_LD;
			end
			ST_ENT_LD: begin
				cmd.ent_ld = 1'b1;
				state_d    = ST_LOG_GO;
			end
			ST_LOG_GO: begin
				// skip empty subsets
				if (stat.grp_empty) begin
					state_d = ST_NEXT;
				end else begin
					cmd.log_start = 1'b1;
					state_d       = ST_LOG_WT;
				end
			end
			ST_LOG_WT: begin
				if (stat.log_done) begin
					if (stat.sel_n) begin
						cmd.sel_next = 1'b1;
						state_d      = ST_LOG_GO;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (stat.sel_c1) begin
					state_d = ST_NEXT;
				end else begin
					cmd.sel_next = 1'b1;
					state_d      = ST_LOG_GO;
				end
			end
			ST_NEXT: begin
				priority if (stat.grp_par) begin
					state_d = ST_ENT_RD;
				end else if (stat.idx_last) begin
					state_d = ST_GAIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_ENT_RD;
				end
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = ST_DIVG_GO;
			end
			ST_DIVG_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_GAIN;
				state_d       = ST_DIVG_WT;
			end
			ST_DIVG_WT: begin
				if (stat.div_done) state_d = ST_DIVP_GO;
			end
			ST_DIVP_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_PAR;
				state_d       = ST_DIVP_WT;
			end
			ST_DIVP_WT: begin
				if (stat.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_log_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.log_done |-> state_q == ST_LOG_WT)
		else $error("log result arrived outside wait state");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_DIVG_WT || state_q == ST_DIVP_WT))
		else $error("quotient arrived outside wait state");

	a_row_wr_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROW_WR |-> $past(state_q == ST_IDLE && start))
		else $error("row write-back without an accepted item");

endmodule

`default_nettype wire

@@ design/information_gain_calc_unit.sv @@
// Information gain calculator: a row item is accepted when start is high and busy low. Each item
// goes through a count read and then a write-back; no new item is taken until the write-back is
// done. A last row then runs the entropy pass: a setup step, then for each group (whole set plus
// each value) a count read for value groups and, unless the group is empty, three logs (total,
// class 0, class 1), each class log followed by a multiply and accumulate. Then the gain difference
// is formed, two divisions run and the result is emitted; done pulses one cycle with the result.
// Reset clears the row counters and valid bits and sets number_of_values to 2; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module information_gain_calc_unit #(
	parameter int MAX_VALUES = igc_pkg::DEF_MAX_VALUES,
	parameter int MAX_ROWS   = igc_pkg::DEF_MAX_ROWS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire igc_pkg::row_t             row,
	input  wire logic                      cfg_we,
	input  wire logic [igc_pkg::NV_W-1:0]  cfg_wdata,
	output logic                           done,
	output igc_pkg::res_t                  result
);
	import igc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	igc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	igc_dp #(
		.MAX_VALUES (MAX_VALUES),
		.MAX_ROWS   (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.row       (row),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire
